// ===== hdl/observer_state_feedback_euler_sim_unit_defines.svh =====
// Assertion macros shared by the observer simulation RTL.
`ifndef OBSERVER_STATE_FEEDBACK_EULER_SIM_UNIT_DEFINES_SVH
`define OBSERVER_STATE_FEEDBACK_EULER_SIM_UNIT_DEFINES_SVH

// The property must hold in the same cycle as its trigger.
`define OSF_ASSERT_SAME(label, clk, rst_n, cond, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (cond) |-> (prop)) \
        else $error(msg);

// The property must hold in the cycle after its trigger.
`define OSF_ASSERT_NEXT(label, clk, rst_n, cond, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (cond) |=> (prop)) \
        else $error(msg);

`endif

// ===== hdl/osf_pkg.sv =====
// Shared types, constants and the per-step micro-operation table of the observer simulation.
package osf_pkg;

    localparam int CFG_IDX_W     = 2;
    localparam int CFG_DATA_W    = 48;
    localparam int DT_W          = 24;
    localparam int DT_FRAC       = 24;
    localparam int OUT_W         = 48;
    localparam int STEPS_W       = 12;
    localparam int ELAPSED_W     = 32;
    localparam int DIGIT_BITS    = 16;
    localparam int COEF_INT_BITS = 10;
    localparam int UOP_IDX_W     = 4;

    localparam logic [CFG_IDX_W-1:0] CFG_DT_STEP          = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_INITIAL_POSITION = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_INITIAL_VELOCITY = 2'd2;

    localparam logic [DT_W-1:0]              DT_RESET       = 24'd16777;
    localparam logic signed [CFG_DATA_W-1:0] INIT_POS_RESET = 48'sd838860800;
    localparam logic signed [CFG_DATA_W-1:0] INIT_VEL_RESET = -48'sd335544320;

    typedef enum logic [3:0] {
        SRC_ZERO,
        SRC_X1,
        SRC_X2,
        SRC_N1,
        SRC_N2,
        SRC_U,
        SRC_T1,
        SRC_TQ,
        SRC_PROD
    } src_t;

    typedef enum logic [2:0] {
        COEF_DT,
        COEF_4P9,
        COEF_0P25,
        COEF_819P6,
        COEF_408,
        COEF_102,
        COEF_M200,
        COEF_204P9
    } coef_t;

    typedef enum logic [2:0] {
        DST_NX1,
        DST_NX2,
        DST_NN1,
        DST_NN2,
        DST_NU,
        DST_T1,
        DST_TQ
    } dst_t;

    typedef struct packed {
        logic  use_mul;
        src_t  mul_src;
        coef_t coef;
        src_t  alu_a;
        src_t  alu_b;
        logic  alu_sub;
        dst_t  dst;
    } uop_t;

    typedef struct packed {
        logic reload;
        logic clear_flag;
        logic mul_acc;
        logic mul_round;
        logic alu_en;
        logic commit;
        logic out_load;
        uop_t uop;
    } dp_cmd_t;

    typedef struct packed {
        logic mul_last;
    } dp_status_t;

    localparam logic [UOP_IDX_W-1:0] UOP_LAST = 4'd13;

    function automatic uop_t mk_uop(input logic use_mul, input src_t mul_src,
                                    input coef_t coef, input src_t alu_a,
                                    input src_t alu_b, input logic alu_sub,
                                    input dst_t dst);
        uop_t u;
        u.use_mul = use_mul;
        u.mul_src = mul_src;
        u.coef    = coef;
        u.alu_a   = alu_a;
        u.alu_b   = alu_b;
        u.alu_sub = alu_sub;
        u.dst     = dst;
        return u;
    endfunction

    // One Euler step. New states go to the NX/NN/NU registers so that every
    // operation sees the values from before the step; commit copies them over.
    function automatic uop_t uop_entry(input logic [UOP_IDX_W-1:0] idx);
        uop_t u;
        unique case (idx)
            4'd0:    u = mk_uop(1'b1, SRC_X2, COEF_DT, SRC_X1, SRC_PROD, 1'b0, DST_NX1);
            4'd1:    u = mk_uop(1'b1, SRC_X1, COEF_4P9, SRC_PROD, SRC_ZERO, 1'b0, DST_T1);
            4'd2:    u = mk_uop(1'b1, SRC_U, COEF_0P25, SRC_PROD, SRC_ZERO, 1'b0, DST_TQ);
            4'd3:    u = mk_uop(1'b0, SRC_ZERO, COEF_DT, SRC_T1, SRC_TQ, 1'b1, DST_T1);
            4'd4:    u = mk_uop(1'b1, SRC_T1, COEF_DT, SRC_X2, SRC_PROD, 1'b0, DST_NX2);
            4'd5:    u = mk_uop(1'b1, SRC_N1, COEF_819P6, SRC_PROD, SRC_ZERO, 1'b0, DST_T1);
            4'd6:    u = mk_uop(1'b1, SRC_N2, COEF_408, SRC_T1, SRC_PROD, 1'b0, DST_NU);
            4'd7:    u = mk_uop(1'b0, SRC_ZERO, COEF_DT, SRC_X1, SRC_N1, 1'b1, DST_T1);
            4'd8:    u = mk_uop(1'b1, SRC_T1, COEF_102, SRC_PROD, SRC_N2, 1'b0, DST_T1);
            4'd9:    u = mk_uop(1'b1, SRC_T1, COEF_DT, SRC_N1, SRC_PROD, 1'b0, DST_NN1);
            4'd10:   u = mk_uop(1'b1, SRC_N1, COEF_M200, SRC_PROD, SRC_ZERO, 1'b0, DST_T1);
            4'd11:   u = mk_uop(1'b1, SRC_X1, COEF_204P9, SRC_T1, SRC_PROD, 1'b0, DST_T1);
            4'd12:   u = mk_uop(1'b0, SRC_ZERO, COEF_DT, SRC_T1, SRC_TQ, 1'b1, DST_T1);
            4'd13:   u = mk_uop(1'b1, SRC_T1, COEF_DT, SRC_N2, SRC_PROD, 1'b0, DST_NN2);
            default: u = mk_uop(1'b0, SRC_ZERO, COEF_DT, SRC_ZERO, SRC_ZERO, 1'b0, DST_T1);
        endcase
        return u;
    endfunction

endpackage

// ===== hdl/osf_if.sv =====
// Request and result channel interfaces of the observer simulation.
interface osf_req_if;
    logic                             valid;
    logic                             ready;
    logic [osf_pkg::STEPS_W-1:0]      step_count;
    logic                             restart;

    modport source (output valid, output step_count, output restart, input ready);
    modport sink (input valid, input step_count, input restart, output ready);
endinterface

interface osf_rsp_if;
    logic                             valid;
    logic                             ready;
    logic signed [osf_pkg::OUT_W-1:0] plant_position;
    logic signed [osf_pkg::OUT_W-1:0] plant_velocity;
    logic signed [osf_pkg::OUT_W-1:0] observer_first;
    logic signed [osf_pkg::OUT_W-1:0] observer_second;
    logic signed [osf_pkg::OUT_W-1:0] control_drive;
    logic [osf_pkg::ELAPSED_W-1:0]    elapsed_steps;
    logic                             saturated;

    modport source (
        output valid, output plant_position, output plant_velocity,
        output observer_first, output observer_second, output control_drive,
        output elapsed_steps, output saturated, input ready
    );
    modport sink (
        input valid, input plant_position, input plant_velocity,
        input observer_first, input observer_second, input control_drive,
        input elapsed_steps, input saturated, output ready
    );
endinterface

// ===== hdl/osf_ctrl.sv =====
// Sequencer that walks the micro-operations of each Euler step and handles both channels.
`include "observer_state_feedback_euler_sim_unit_defines.svh"

module osf_ctrl #(
    parameter int MAX_STEPS = 4095
) (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        in_valid,
    output logic                        in_ready,
    input  logic [osf_pkg::STEPS_W-1:0] step_count,
    input  logic                        restart,
    output logic                        out_valid,
    input  logic                        out_ready,
    input  osf_pkg::dp_status_t         status,
    output osf_pkg::dp_cmd_t            cmd
);

    localparam int SCW  = $clog2(MAX_STEPS + 1);
    localparam int CMPW = (SCW > osf_pkg::STEPS_W) ? SCW : osf_pkg::STEPS_W;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_MUL,
        ST_ROUND,
        ST_ALU,
        ST_COMMIT,
        ST_DONE
    } state_t;

    state_t                           state_reg, state_next;
    logic [osf_pkg::UOP_IDX_W-1:0]    uop_idx_reg, uop_idx_next;
    logic [SCW-1:0]                   remaining_reg, remaining_next;
    logic                             out_valid_reg, out_valid_next;
    logic [SCW-1:0]                   clamped;
    logic [CMPW-1:0]                  count_ext;
    osf_pkg::uop_t                    uop_first;
    osf_pkg::uop_t                    uop_follow;
    state_t                           first_state;
    state_t                           follow_state;

    always_comb
    begin
        count_ext = CMPW'(step_count);
        if (count_ext > CMPW'(MAX_STEPS))
        begin
            clamped = SCW'(MAX_STEPS);
        end
        else
        begin
            clamped = SCW'(count_ext);
        end
    end

    assign uop_first    = osf_pkg::uop_entry('0);
    assign uop_follow   = osf_pkg::uop_entry(uop_idx_reg + 1'b1);
    assign first_state  = uop_first.use_mul ? ST_MUL : ST_ALU;
    assign follow_state = uop_follow.use_mul ? ST_MUL : ST_ALU;

    always_comb
    begin
        cmd            = '0;
        cmd.uop        = osf_pkg::uop_entry(uop_idx_reg);
        state_next     = state_reg;
        uop_idx_next   = uop_idx_reg;
        remaining_next = remaining_reg;
        out_valid_next = out_valid_reg && !out_ready;
        in_ready       = 1'b0;
        unique case (state_reg)
            ST_IDLE:
            begin
                in_ready = 1'b1;
                if (in_valid)
                begin
                    cmd.clear_flag = 1'b1;
                    cmd.reload     = restart;
                    remaining_next = clamped;
                    uop_idx_next   = '0;
                    state_next     = (clamped == '0) ? ST_DONE : first_state;
                end
            end
            ST_MUL:
            begin
                cmd.mul_acc = 1'b1;
                if (status.mul_last)
                begin
                    state_next = ST_ROUND;
                end
            end
            ST_ROUND:
            begin
                cmd.mul_round = 1'b1;
                state_next    = ST_ALU;
            end
            ST_ALU:
            begin
                cmd.alu_en = 1'b1;
                if (uop_idx_reg == osf_pkg::UOP_LAST)
                begin
                    state_next = ST_COMMIT;
                end
                else
                begin
                    uop_idx_next = uop_idx_reg + 1'b1;
                    state_next   = follow_state;
                end
            end
            ST_COMMIT:
            begin
                cmd.commit     = 1'b1;
                remaining_next = remaining_reg - 1'b1;
                uop_idx_next   = '0;
                state_next     = (remaining_reg == SCW'(1)) ? ST_DONE : first_state;
            end
            ST_DONE:
            begin
                // The result register may be refilled in the cycle its item is taken.
                if (!out_valid_reg || out_ready)
                begin
                    cmd.out_load   = 1'b1;
                    out_valid_next = 1'b1;
                    state_next     = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    assign out_valid = out_valid_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            uop_idx_reg   <= '0;
            remaining_reg <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            uop_idx_reg   <= uop_idx_next;
            remaining_reg <= remaining_next;
            out_valid_reg <= out_valid_next;
        end
    end

    `OSF_ASSERT_SAME(a_load_when_free, clk, rst_n, cmd.out_load, (!out_valid_reg || out_ready), "result register overwritten before its item was taken")
    `OSF_ASSERT_NEXT(a_accept_blocks, clk, rst_n, (in_valid && in_ready), !in_ready, "second item accepted while one is in progress")
    `OSF_ASSERT_SAME(a_commit_counted, clk, rst_n, cmd.commit, (remaining_reg != '0), "Euler step committed with no steps left")
    `OSF_ASSERT_SAME(a_mul_for_mul_uop, clk, rst_n, cmd.mul_acc, cmd.uop.use_mul, "multiplier run for an operation without a product")

endmodule

// ===== hdl/osf_datapath.sv =====
// State registers, sequential multiplier with rounding and saturating adder of the observer simulation.
module osf_datapath #(
    parameter int STATE_WIDTH   = 48,
    parameter int FRACTION_BITS = 24
) (
    input  logic                               clk,
    input  logic                               rst_n,
    input  logic                               cfg_we,
    input  logic [osf_pkg::CFG_IDX_W-1:0]      cfg_index,
    input  logic [osf_pkg::CFG_DATA_W-1:0]     cfg_data,
    input  osf_pkg::dp_cmd_t                   cmd,
    output osf_pkg::dp_status_t                status,
    output logic signed [osf_pkg::OUT_W-1:0]   plant_position,
    output logic signed [osf_pkg::OUT_W-1:0]   plant_velocity,
    output logic signed [osf_pkg::OUT_W-1:0]   observer_first,
    output logic signed [osf_pkg::OUT_W-1:0]   observer_second,
    output logic signed [osf_pkg::OUT_W-1:0]   control_drive,
    output logic [osf_pkg::ELAPSED_W-1:0]      elapsed_steps,
    output logic                               saturated
);

    localparam int W    = STATE_WIDTH;
    localparam int FB   = FRACTION_BITS;
    localparam int DB   = osf_pkg::DIGIT_BITS;
    localparam int KW   = (FB + osf_pkg::COEF_INT_BITS > osf_pkg::DT_W) ?
                          (FB + osf_pkg::COEF_INT_BITS) : osf_pkg::DT_W;
    localparam int NDIG = (KW + DB - 1) / DB;
    localparam int DCW  = $clog2(NDIG);
    localparam int KPAD = NDIG * DB;
    localparam int PW   = W + KPAD;
    localparam int RW   = PW + 1;
    localparam int XW   = (W > osf_pkg::OUT_W) ? W : osf_pkg::OUT_W;

    localparam logic signed [W-1:0] SMAX = {1'b0, {(W - 1){1'b1}}};
    localparam logic signed [W-1:0] SMIN = {1'b1, {(W - 1){1'b0}}};
    localparam logic signed [W-1:0] RESET_POS = W'(osf_pkg::INIT_POS_RESET);
    localparam logic signed [W-1:0] RESET_VEL = W'(osf_pkg::INIT_VEL_RESET);

    // Coefficients rounded to nearest, ties away from zero.
    localparam logic [63:0] Q_4P9   = ((64'd49 << FB) * 64'd2 + 64'd10) / 64'd20;
    localparam logic [63:0] Q_0P25  = ((64'd1 << FB) * 64'd2 + 64'd4) / 64'd8;
    localparam logic [63:0] Q_819P6 = ((64'd8196 << FB) * 64'd2 + 64'd10) / 64'd20;
    localparam logic [63:0] Q_204P9 = ((64'd2049 << FB) * 64'd2 + 64'd10) / 64'd20;
    localparam logic [KW-1:0] K_4P9   = KW'(Q_4P9);
    localparam logic [KW-1:0] K_0P25  = KW'(Q_0P25);
    localparam logic [KW-1:0] K_819P6 = KW'(Q_819P6);
    localparam logic [KW-1:0] K_408   = KW'(64'd408 << FB);
    localparam logic [KW-1:0] K_102   = KW'(64'd102 << FB);
    localparam logic [KW-1:0] K_200   = KW'(64'd200 << FB);
    localparam logic [KW-1:0] K_204P9 = KW'(Q_204P9);

    localparam logic [RW-1:0] HALF_FB = RW'(1) << (FB - 1);
    localparam logic [RW-1:0] HALF_DT = RW'(1) << (osf_pkg::DT_FRAC - 1);
    localparam logic [RW-1:0] LIM_NEG = RW'(1) << (W - 1);
    localparam logic [RW-1:0] LIM_POS = LIM_NEG - RW'(1);

    // Configuration registers.
    logic [osf_pkg::DT_W-1:0]             dt_reg;
    logic signed [osf_pkg::CFG_DATA_W-1:0] init_pos_reg;
    logic signed [osf_pkg::CFG_DATA_W-1:0] init_vel_reg;

    // Architectural state and step scratch registers.
    logic signed [W-1:0] x1_reg, x2_reg, n1_reg, n2_reg, u_reg;
    logic signed [W-1:0] nx1_reg, nx2_reg, nn1_reg, nn2_reg, nu_reg;
    logic signed [W-1:0] t1_reg, tq_reg, prod_reg;
    logic [osf_pkg::ELAPSED_W-1:0] elapsed_reg;
    logic                          flag_reg;

    // Multiplier.
    logic [PW-1:0]        acc_reg, acc_next;
    logic [DCW-1:0]       dig_cnt_reg;
    logic signed [W-1:0]  mul_a;
    logic                 a_neg, b_neg, prod_neg, is_dt;
    logic [W-1:0]         a_mag;
    logic [KW-1:0]        b_mag;
    logic [KPAD-1:0]      b_pad;
    logic [DB-1:0]        digits [NDIG];
    logic [W+DB-1:0]      partial;
    logic [RW-1:0]        rsum, rnd, limit;
    logic [W-1:0]         rnd_low;
    logic                 rnd_clip;
    logic signed [W-1:0]  rnd_val;

    // Adder.
    logic signed [W-1:0]  alu_a, alu_b, alu_val;
    logic signed [W:0]    alu_sum;
    logic                 alu_clip;

    // Reload values.
    logic signed [XW-1:0] pos_ext, vel_ext;
    logic                 pos_fit, vel_fit;
    logic signed [W-1:0]  pos_load, vel_load;

    function automatic logic signed [W-1:0] pick(
        input osf_pkg::src_t       sel,
        input logic signed [W-1:0] x1,
        input logic signed [W-1:0] x2,
        input logic signed [W-1:0] n1,
        input logic signed [W-1:0] n2,
        input logic signed [W-1:0] u,
        input logic signed [W-1:0] t1,
        input logic signed [W-1:0] tq,
        input logic signed [W-1:0] p
    );
        logic signed [W-1:0] v;
        unique case (sel)
            osf_pkg::SRC_ZERO: v = '0;
            osf_pkg::SRC_X1:   v = x1;
            osf_pkg::SRC_X2:   v = x2;
            osf_pkg::SRC_N1:   v = n1;
            osf_pkg::SRC_N2:   v = n2;
            osf_pkg::SRC_U:    v = u;
            osf_pkg::SRC_T1:   v = t1;
            osf_pkg::SRC_TQ:   v = tq;
            osf_pkg::SRC_PROD: v = p;
            default:           v = '0;
        endcase
        return v;
    endfunction

    // Operand A is taken as sign and magnitude; the magnitude of the most
    // negative value still fits W unsigned bits.
    always_comb
    begin
        mul_a = pick(cmd.uop.mul_src, x1_reg, x2_reg, n1_reg, n2_reg, u_reg,
                     t1_reg, tq_reg, prod_reg);
        a_neg = mul_a[W-1];
        a_mag = a_neg ? (~$unsigned(mul_a) + 1'b1) : $unsigned(mul_a);
        b_neg = 1'b0;
        unique case (cmd.uop.coef)
            osf_pkg::COEF_DT:    b_mag = KW'(dt_reg);
            osf_pkg::COEF_4P9:   b_mag = K_4P9;
            osf_pkg::COEF_0P25:  b_mag = K_0P25;
            osf_pkg::COEF_819P6: b_mag = K_819P6;
            osf_pkg::COEF_408:   b_mag = K_408;
            osf_pkg::COEF_102:   b_mag = K_102;
            osf_pkg::COEF_M200:
            begin
                b_mag = K_200;
                b_neg = 1'b1;
            end
            osf_pkg::COEF_204P9: b_mag = K_204P9;
            default:             b_mag = '0;
        endcase
        b_pad = KPAD'(b_mag);
        for (int i = 0; i < NDIG; i++)
        begin
            digits[i] = b_pad[i*DB +: DB];
        end
    end

    // One 16-bit digit of the coefficient per cycle, lowest digit first.
    always_comb
    begin
        partial  = a_mag * digits[dig_cnt_reg];
        acc_next = ((dig_cnt_reg == '0) ? '0 : acc_reg)
                   + (PW'(partial) << (DB * dig_cnt_reg));
    end

    assign status.mul_last = (dig_cnt_reg == DCW'(NDIG - 1));

    always_comb
    begin
        prod_neg = a_neg ^ b_neg;
        is_dt    = (cmd.uop.coef == osf_pkg::COEF_DT);
        rsum     = RW'(acc_reg) + (is_dt ? HALF_DT : HALF_FB);
        rnd      = is_dt ? (rsum >> osf_pkg::DT_FRAC) : (rsum >> FB);
        limit    = prod_neg ? LIM_NEG : LIM_POS;
        rnd_clip = (rnd > limit);
        rnd_low  = rnd[W-1:0];
        if (rnd_clip)
        begin
            rnd_val = prod_neg ? SMIN : SMAX;
        end
        else
        begin
            rnd_val = prod_neg ? $signed(~rnd_low + 1'b1) : $signed(rnd_low);
        end
    end

    always_comb
    begin
        alu_a = pick(cmd.uop.alu_a, x1_reg, x2_reg, n1_reg, n2_reg, u_reg,
                     t1_reg, tq_reg, prod_reg);
        alu_b = pick(cmd.uop.alu_b, x1_reg, x2_reg, n1_reg, n2_reg, u_reg,
                     t1_reg, tq_reg, prod_reg);
        if (cmd.uop.alu_sub)
        begin
            alu_sum = {alu_a[W-1], alu_a} - {alu_b[W-1], alu_b};
        end
        else
        begin
            alu_sum = {alu_a[W-1], alu_a} + {alu_b[W-1], alu_b};
        end
        alu_clip = (alu_sum[W] != alu_sum[W-1]);
        if (alu_clip)
        begin
            alu_val = alu_sum[W] ? SMIN : SMAX;
        end
        else
        begin
            alu_val = alu_sum[W-1:0];
        end
    end

    // Reload values are clipped to the state range when the state is narrower.
    always_comb
    begin
        pos_ext  = XW'(init_pos_reg);
        vel_ext  = XW'(init_vel_reg);
        pos_fit  = (&pos_ext[XW-1:W-1]) || !(|pos_ext[XW-1:W-1]);
        vel_fit  = (&vel_ext[XW-1:W-1]) || !(|vel_ext[XW-1:W-1]);
        pos_load = pos_fit ? pos_ext[W-1:0] : (pos_ext[XW-1] ? SMIN : SMAX);
        vel_load = vel_fit ? vel_ext[W-1:0] : (vel_ext[XW-1] ? SMIN : SMAX);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            dt_reg       <= osf_pkg::DT_RESET;
            init_pos_reg <= osf_pkg::INIT_POS_RESET;
            init_vel_reg <= osf_pkg::INIT_VEL_RESET;
            dig_cnt_reg  <= '0;
            x1_reg       <= RESET_POS;
            x2_reg       <= RESET_VEL;
            n1_reg       <= RESET_POS;
            n2_reg       <= '0;
            u_reg        <= '0;
            elapsed_reg  <= '0;
            flag_reg     <= 1'b0;
        end
        else
        begin
            if (cfg_we)
            begin
                unique case (cfg_index)
                    osf_pkg::CFG_DT_STEP:          dt_reg <= cfg_data[osf_pkg::DT_W-1:0];
                    osf_pkg::CFG_INITIAL_POSITION: init_pos_reg <= cfg_data;
                    osf_pkg::CFG_INITIAL_VELOCITY: init_vel_reg <= cfg_data;
                    default:                       ;
                endcase
            end
            if (cmd.mul_acc)
            begin
                dig_cnt_reg <= status.mul_last ? '0 : dig_cnt_reg + 1'b1;
            end
            if (cmd.reload)
            begin
                x1_reg      <= pos_load;
                n1_reg      <= pos_load;
                x2_reg      <= vel_load;
                n2_reg      <= '0;
                u_reg       <= '0;
                elapsed_reg <= '0;
            end
            else if (cmd.commit)
            begin
                x1_reg      <= nx1_reg;
                x2_reg      <= nx2_reg;
                n1_reg      <= nn1_reg;
                n2_reg      <= nn2_reg;
                u_reg       <= nu_reg;
                elapsed_reg <= elapsed_reg + 1'b1;
            end
            if (cmd.clear_flag)
            begin
                flag_reg <= cmd.reload && !(pos_fit && vel_fit);
            end
            else if ((cmd.mul_round && rnd_clip) || (cmd.alu_en && alu_clip))
            begin
                flag_reg <= 1'b1;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.mul_acc)
        begin
            acc_reg <= acc_next;
        end
        if (cmd.mul_round)
        begin
            prod_reg <= rnd_val;
        end
        if (cmd.alu_en)
        begin
            unique case (cmd.uop.dst)
                osf_pkg::DST_NX1: nx1_reg <= alu_val;
                osf_pkg::DST_NX2: nx2_reg <= alu_val;
                osf_pkg::DST_NN1: nn1_reg <= alu_val;
                osf_pkg::DST_NN2: nn2_reg <= alu_val;
                osf_pkg::DST_NU:  nu_reg  <= alu_val;
                osf_pkg::DST_T1:  t1_reg  <= alu_val;
                osf_pkg::DST_TQ:  tq_reg  <= alu_val;
                default:          ;
            endcase
        end
    end

    // Result register; states are sign-extended before the low 48 bits are taken.
    logic signed [XW-1:0] x1_ext, x2_ext, n1_ext, n2_ext, u_ext;
    assign x1_ext = XW'(x1_reg);
    assign x2_ext = XW'(x2_reg);
    assign n1_ext = XW'(n1_reg);
    assign n2_ext = XW'(n2_reg);
    assign u_ext  = XW'(u_reg);

    always_ff @(posedge clk)
    begin
        if (cmd.out_load)
        begin
            plant_position  <= x1_ext[osf_pkg::OUT_W-1:0];
            plant_velocity  <= x2_ext[osf_pkg::OUT_W-1:0];
            observer_first  <= n1_ext[osf_pkg::OUT_W-1:0];
            observer_second <= n2_ext[osf_pkg::OUT_W-1:0];
            control_drive   <= u_ext[osf_pkg::OUT_W-1:0];
            elapsed_steps   <= elapsed_reg;
            saturated       <= flag_reg;
        end
    end

endmodule

// ===== hdl/observer_state_feedback_euler_sim_unit.sv =====
// Each Euler step runs its eleven products through the shared multiplier, which forms one 16-bit
// coefficient digit per cycle; a product has D = ceil(max(FB + 10, 24) / 16) digits, and with
// the default widths D is 3.
// One item is worked on at a time; the next is accepted while the last result waits.
// Reset loads the default configuration and the initial states and clears the step count.
module observer_state_feedback_euler_sim_unit #(
    parameter int STATE_WIDTH   = 48,
    parameter int FRACTION_BITS = 24,
    parameter int MAX_STEPS     = 4095
) (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           cfg_we,
    input  logic [osf_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  logic [osf_pkg::CFG_DATA_W-1:0] cfg_data,
    osf_req_if.sink                        step_req,
    osf_rsp_if.source                      result
);

    osf_pkg::dp_cmd_t    cmd;
    osf_pkg::dp_status_t status;

    osf_ctrl #(
        .MAX_STEPS (MAX_STEPS)
    ) u_ctrl (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (step_req.valid),
        .in_ready   (step_req.ready),
        .step_count (step_req.step_count),
        .restart    (step_req.restart),
        .out_valid  (result.valid),
        .out_ready  (result.ready),
        .status     (status),
        .cmd        (cmd)
    );

    osf_datapath #(
        .STATE_WIDTH   (STATE_WIDTH),
        .FRACTION_BITS (FRACTION_BITS)
    ) u_datapath (
        .clk             (clk),
        .rst_n           (rst_n),
        .cfg_we          (cfg_we),
        .cfg_index       (cfg_index),
        .cfg_data        (cfg_data),
        .cmd             (cmd),
        .status          (status),
        .plant_position  (result.plant_position),
        .plant_velocity  (result.plant_velocity),
        .observer_first  (result.observer_first),
        .observer_second (result.observer_second),
        .control_drive   (result.control_drive),
        .elapsed_steps   (result.elapsed_steps),
        .saturated       (result.saturated)
    );

endmodule

// ===== test/observer_state_feedback_euler_sim_unit_tb.sv =====
`timescale 1ns / 1ps
// Self-checking testbench for the Euler observer simulation unit, with a fixed-point predictor.
module observer_state_feedback_euler_sim_unit_tb;

    localparam int     STATE_W     = 48;
    localparam int     FRAC        = 24;
    localparam int     STEP_LIMIT  = 4095;
    localparam int     QUIET_LIMIT = 1000000;
    localparam int     LONG_HOLD   = 3000;
    localparam int     PHASES      = 5;
    localparam int     PHASE_ITEMS = 40;
    localparam longint STATE_MAX   = (longint'(1) <<< (STATE_W - 1)) - 1;
    localparam longint STATE_MIN   = -STATE_MAX - 1;

    // Decimal coefficient num/den in Q.24, rounded to nearest with ties away from zero.
    function automatic longint q_const(input longint num, input longint den);
        return ((num <<< (FRAC + 1)) + den) / (2 * den);
    endfunction

    localparam longint K_4P9   = q_const(49, 10);
    localparam longint K_0P25  = q_const(1, 4);
    localparam longint K_819P6 = q_const(8196, 10);
    localparam longint K_408   = q_const(408, 1);
    localparam longint K_102   = q_const(102, 1);
    localparam longint K_M200  = -q_const(200, 1);
    localparam longint K_204P9 = q_const(2049, 10);

    typedef struct packed {
        logic [osf_pkg::STEPS_W-1:0] count;
        logic                        restart;
    } step_req_t;

    typedef struct packed {
        logic signed [osf_pkg::OUT_W-1:0] position;
        logic signed [osf_pkg::OUT_W-1:0] velocity;
        logic signed [osf_pkg::OUT_W-1:0] obs_first;
        logic signed [osf_pkg::OUT_W-1:0] obs_second;
        logic signed [osf_pkg::OUT_W-1:0] drive;
        logic [osf_pkg::ELAPSED_W-1:0]    elapsed;
        logic                             saturated;
    } sim_state_t;

    logic                           clk = 1'b0;
    logic                           rst_n;
    logic                           cfg_we;
    logic [osf_pkg::CFG_IDX_W-1:0]  cfg_index;
    logic [osf_pkg::CFG_DATA_W-1:0] cfg_data;

    osf_req_if step_req_ch ();
    osf_rsp_if result_ch ();

    observer_state_feedback_euler_sim_unit dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .step_req  (step_req_ch),
        .result    (result_ch)
    );

    // Predictor copy of the configuration and the simulated states.
    logic [osf_pkg::DT_W-1:0]       dt_m;
    logic [osf_pkg::CFG_DATA_W-1:0] init_pos_m;
    logic [osf_pkg::CFG_DATA_W-1:0] init_vel_m;
    longint                         x1_m, x2_m, n1_m, n2_m, u_m;
    logic [osf_pkg::ELAPSED_W-1:0]  steps_m;
    logic                           clip_seen;

    step_req_t  step_requests[$];
    sim_state_t predicted[$];
    step_req_t  offer;
    sim_state_t forecast;
    sim_state_t want;

    int  send_idle_pct;
    int  recv_idle_pct;
    bit  hold_toggle;
    bit  hold_seen;
    int  hold_left;
    int  mismatches;
    int  items_sent;
    int  results_checked;
    int  clipped_items;
    int  settings_written;

    always
    begin
        #1 clk = 1'b1;
        #1 clk = 1'b0;
    end

    function automatic longint clamp_state(input longint v);
        if (v > STATE_MAX)
        begin
            clip_seen = 1'b1;
            return STATE_MAX;
        end
        if (v < STATE_MIN)
        begin
            clip_seen = 1'b1;
            return STATE_MIN;
        end
        return v;
    endfunction

    // Exact product, shifted down by the fraction width with rounding, then clipped.
    function automatic longint scaled_mul(input longint a, input longint b);
        logic [127:0] mag;
        logic [127:0] lim;
        logic [63:0]  ua;
        logic [63:0]  ub;
        logic         neg;
        neg = (a < 0) != (b < 0);
        ua  = (a < 0) ? -a : a;
        ub  = (b < 0) ? -b : b;
        mag = {64'd0, ua} * {64'd0, ub};
        mag = (mag + (128'd1 << (FRAC - 1))) >> FRAC;
        lim = {64'd0, STATE_MAX};
        if (neg)
            lim = lim + 1;
        if (mag > lim)
        begin
            clip_seen = 1'b1;
            return neg ? STATE_MIN : STATE_MAX;
        end
        return neg ? -longint'(mag[63:0]) : longint'(mag[63:0]);
    endfunction

    function automatic void reload_states();
        x1_m    = clamp_state(longint'($signed(init_pos_m)));
        n1_m    = x1_m;
        x2_m    = clamp_state(longint'($signed(init_vel_m)));
        n2_m    = 0;
        u_m     = 0;
        steps_m = '0;
    endfunction

    // Every right-hand side uses the values from before the step.
    function automatic void euler_update();
        longint x1, x2, n1, n2, u, dt, acc;
        x1   = x1_m;
        x2   = x2_m;
        n1   = n1_m;
        n2   = n2_m;
        u    = u_m;
        dt   = longint'(dt_m);
        x1_m = clamp_state(x1 + scaled_mul(x2, dt));
        acc  = clamp_state(scaled_mul(x1, K_4P9) - scaled_mul(u, K_0P25));
        x2_m = clamp_state(x2 + scaled_mul(acc, dt));
        u_m  = clamp_state(scaled_mul(n1, K_819P6) + scaled_mul(n2, K_408));
        acc  = clamp_state(scaled_mul(clamp_state(x1 - n1), K_102) + n2);
        n1_m = clamp_state(n1 + scaled_mul(acc, dt));
        acc  = clamp_state(scaled_mul(n1, K_M200) + scaled_mul(x1, K_204P9));
        acc  = clamp_state(acc - scaled_mul(u, K_0P25));
        n2_m = clamp_state(n2 + scaled_mul(acc, dt));
        steps_m = steps_m + 1;
    endfunction

    function automatic sim_state_t run_request(input logic [osf_pkg::STEPS_W-1:0] count,
                                               input logic restart);
        sim_state_t r;
        int         n;
        clip_seen = 1'b0;
        if (restart)
            reload_states();
        n = count;
        if (n > STEP_LIMIT)
            n = STEP_LIMIT;
        for (int i = 0; i < n; i++)
            euler_update();
        r.position   = x1_m[osf_pkg::OUT_W-1:0];
        r.velocity   = x2_m[osf_pkg::OUT_W-1:0];
        r.obs_first  = n1_m[osf_pkg::OUT_W-1:0];
        r.obs_second = n2_m[osf_pkg::OUT_W-1:0];
        r.drive      = u_m[osf_pkg::OUT_W-1:0];
        r.elapsed    = steps_m;
        r.saturated  = clip_seen;
        return r;
    endfunction

    function automatic void check_field(input string name, input longint exp_v,
                                        input longint got_v);
        if (exp_v != got_v)
        begin
            $error("%s: expected %0d, got %0d", name, exp_v, got_v);
            mismatches++;
        end
    endfunction

    // Mostly moderate magnitudes so that runs last a while before clipping.
    function automatic logic [osf_pkg::CFG_DATA_W-1:0] rand_state();
        logic [63:0] raw;
        int          span;
        raw = {$urandom, $urandom};
        if ($urandom_range(9) == 0)
            return raw[osf_pkg::CFG_DATA_W-1:0];
        span = $urandom_range(47, 20);
        raw  = raw & ((64'd1 << span) - 1);
        if ($urandom_range(1) == 1)
            raw = -raw;
        return raw[osf_pkg::CFG_DATA_W-1:0];
    endfunction

    function automatic logic [osf_pkg::DT_W-1:0] rand_dt();
        int pick;
        pick = $urandom_range(99);
        if (pick < 10)
            return '0;
        if (pick < 70)
            return osf_pkg::DT_W'($urandom_range(1 << 20, 1));
        return osf_pkg::DT_W'($urandom_range(24'hFFFFFF, 1));
    endfunction

    task automatic push_req(input int count, input bit restart);
        step_req_t r;
        r.count   = osf_pkg::STEPS_W'(count);
        r.restart = restart;
        step_requests.push_back(r);
    endtask

    task automatic drain();
        while (step_requests.size() != 0 || step_req_ch.valid || predicted.size() != 0)
            @(posedge clk);
        repeat (2) @(posedge clk);
    endtask

    task automatic write_reg(input logic [osf_pkg::CFG_IDX_W-1:0] idx,
                             input logic [osf_pkg::CFG_DATA_W-1:0] value);
        @(posedge clk);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= value;
        @(posedge clk);
        cfg_we <= 1'b0;
        case (idx)
            osf_pkg::CFG_DT_STEP:          dt_m = value[osf_pkg::DT_W-1:0];
            osf_pkg::CFG_INITIAL_POSITION: init_pos_m = value;
            osf_pkg::CFG_INITIAL_VELOCITY: init_vel_m = value;
            default: ;
        endcase
        settings_written++;
    endtask

    // Request driver: an accepted item is predicted at the edge that takes it.
    always @(posedge clk)
    begin
        if (!rst_n)
        begin
            step_req_ch.valid <= 1'b0;
        end
        else
        begin
            if (step_req_ch.valid && step_req_ch.ready)
            begin
                forecast = run_request(step_req_ch.step_count, step_req_ch.restart);
                predicted.push_back(forecast);
                items_sent++;
                if (forecast.saturated)
                    clipped_items++;
            end
            if (!step_req_ch.valid || step_req_ch.ready)
            begin
                if (step_requests.size() != 0 && $urandom_range(99) >= send_idle_pct)
                begin
                    offer = step_requests.pop_front();
                    step_req_ch.valid      <= 1'b1;
                    step_req_ch.step_count <= offer.count;
                    step_req_ch.restart    <= offer.restart;
                end
                else
                begin
                    step_req_ch.valid <= 1'b0;
                end
            end
        end
    end

    // Result monitor, which also owns the long hold-off of the result side.
    always @(posedge clk)
    begin
        if (!rst_n)
        begin
            result_ch.ready <= 1'b0;
            hold_left = 0;
        end
        else
        begin
            if (result_ch.valid && result_ch.ready)
            begin
                if (predicted.size() == 0)
                begin
                    $error("result item arrived with no request outstanding");
                    mismatches++;
                end
                else
                begin
                    want = predicted.pop_front();
                    check_field("plant_position", want.position, result_ch.plant_position);
                    check_field("plant_velocity", want.velocity, result_ch.plant_velocity);
                    check_field("observer_first", want.obs_first, result_ch.observer_first);
                    check_field("observer_second", want.obs_second,
                                result_ch.observer_second);
                    check_field("control_drive", want.drive, result_ch.control_drive);
                    check_field("elapsed_steps", want.elapsed, result_ch.elapsed_steps);
                    check_field("saturated", want.saturated, result_ch.saturated);
                    results_checked++;
                end
            end
            if (hold_toggle != hold_seen)
            begin
                hold_seen = hold_toggle;
                hold_left = LONG_HOLD;
            end
            if (hold_left > 0)
            begin
                hold_left--;
                result_ch.ready <= 1'b0;
            end
            else
            begin
                result_ch.ready <= ($urandom_range(99) >= recv_idle_pct);
            end
        end
    end

    initial
    begin : watchdog
        int quiet;
        quiet = 0;
        while (quiet < QUIET_LIMIT)
        begin
            @(posedge clk);
            if ((step_req_ch.valid && step_req_ch.ready) || (result_ch.valid && result_ch.ready))
                quiet = 0;
            else
                quiet++;
        end
        $display("[FAIL] regression broken");
        $finish;
    end

    initial
    begin : stimulus
        int pick;
        rst_n                  = 1'b0;
        cfg_we                 = 1'b0;
        cfg_index              = '0;
        cfg_data               = '0;
        step_req_ch.valid      = 1'b0;
        step_req_ch.step_count = '0;
        step_req_ch.restart    = 1'b0;
        result_ch.ready        = 1'b0;
        send_idle_pct          = 36;
        recv_idle_pct          = 36;
        hold_toggle            = 1'b0;
        hold_seen              = 1'b0;
        mismatches             = 0;
        items_sent             = 0;
        results_checked        = 0;
        clipped_items          = 0;
        settings_written       = 0;
        dt_m                   = osf_pkg::DT_RESET;
        init_pos_m             = osf_pkg::INIT_POS_RESET;
        init_vel_m             = osf_pkg::INIT_VEL_RESET;
        reload_states();
        repeat (6) @(posedge clk);
        rst_n <= 1'b1;

        // Reset state: zero steps, a single step, a full-length run and restarts.
        push_req(0, 1'b0);
        push_req(1, 1'b0);
        push_req(5, 1'b0);
        push_req(0, 1'b1);
        push_req(STEP_LIMIT, 1'b0);
        push_req(7, 1'b1);
        push_req(1, 1'b1);
        drain();

        // Largest step with the state extremes drives everything into clipping.
        write_reg(osf_pkg::CFG_DT_STEP, {24'd0, 24'hFFFFFF});
        write_reg(osf_pkg::CFG_INITIAL_POSITION, {1'b0, {(osf_pkg::CFG_DATA_W-1){1'b1}}});
        write_reg(osf_pkg::CFG_INITIAL_VELOCITY, {1'b1, {(osf_pkg::CFG_DATA_W-1){1'b0}}});
        push_req(0, 1'b1);
        push_req(3, 1'b0);
        push_req(20, 1'b0);
        push_req(1, 1'b1);
        push_req(2, 0);
        drain();

        // With a zero step the states hold while the drive and the count move on.
        write_reg(osf_pkg::CFG_DT_STEP, '0);
        push_req(0, 1'b0);
        push_req(10, 1'b0);
        push_req(2, 1'b1);
        drain();

        write_reg(osf_pkg::CFG_DT_STEP, {24'd0, 24'd1});
        write_reg(osf_pkg::CFG_INITIAL_POSITION, {1'b1, {(osf_pkg::CFG_DATA_W-1){1'b0}}});
        write_reg(osf_pkg::CFG_INITIAL_VELOCITY, {1'b0, {(osf_pkg::CFG_DATA_W-1){1'b1}}});
        push_req(2, 1'b1);
        push_req(50, 1'b0);
        drain();

        for (int phase = 0; phase < PHASES; phase++)
        begin
            write_reg(osf_pkg::CFG_DT_STEP, {24'd0, rand_dt()});
            write_reg(osf_pkg::CFG_INITIAL_POSITION, rand_state());
            write_reg(osf_pkg::CFG_INITIAL_VELOCITY, rand_state());
            send_idle_pct = (phase == 3) ? 0 : 36;
            recv_idle_pct = (phase == 3) ? 0 : 36;
            push_req($urandom_range(15), 1'b1);
            for (int i = 1; i < PHASE_ITEMS; i++)
            begin
                pick = $urandom_range(99);
                if (pick < 85)
                    push_req($urandom_range(15), $urandom_range(99) < 20);
                else if (pick < 98)
                    push_req($urandom_range(127, 16), $urandom_range(99) < 20);
                else
                    push_req($urandom_range(511, 128), $urandom_range(99) < 20);
            end
            // The result side stalls while requests keep coming, so the input backs up.
            if (phase == 1)
                hold_toggle = ~hold_toggle;
            drain();
        end

        repeat (20) @(posedge clk);
        $display("Ran %0d step requests over %0d register writes; %0d results compared, %0d clipped.",
                 items_sent, settings_written, results_checked, clipped_items);
        if (mismatches == 0)
            $display("[ OK ] regression clean");
        else
            $display("[FAIL] regression broken");
        $finish;
    end

endmodule

// ===== observer_state_feedback_euler_sim_unit.f =====
+incdir+hdl
hdl/osf_pkg.sv
hdl/osf_if.sv
hdl/osf_ctrl.sv
hdl/osf_datapath.sv
hdl/observer_state_feedback_euler_sim_unit.sv
test/observer_state_feedback_euler_sim_unit_tb.sv
